[src/brq_pkg.sv]
// Package for the backoff retry request queue.
// Holds item structs, operation and status codes, state and unit-op enums.
// No dependencies.
package brq_pkg;

    localparam int TAG_W      = 6;
    localparam int TAG_COUNT  = 64;
    localparam int TIME_W     = 48;
    localparam int INTERVAL_W = 32;
    localparam int WAIT_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 3;

    localparam logic [KIND_W-1:0] KIND_ENQ     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BACKOFF = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEQ     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESET   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HELD    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic CFG_HOLDOFF_INTERVAL = 1'b0;
    localparam logic CFG_BACKOFF_CAP      = 1'b1;

    localparam logic [INTERVAL_W-1:0] HOLDOFF_RESET = 32'd300000;
    localparam logic [WAIT_W-1:0]     CAP_RESET     = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  request_tag;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                granted;
        logic [TAG_W-1:0]    granted_tag;
    } rsp_t;

    typedef enum logic [1:0] {
        UOP_ADD,
        UOP_LE,
        UOP_DBL,
        UOP_DEC
    } unit_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_BACKOFF,
        S_ENQ_CHK,
        S_ENQ_WR,
        S_TK_RD,
        S_TK_TAG,
        S_TK_UPD,
        S_DQ_RD,
        S_DQ_TAG,
        S_DQ_DEC,
        S_DONE
    } state_t;

endpackage

[src/backoff_retry_request_queue.sv]
// Enqueue passes through the look, backoff (backoff kind only), check and write states; a refused one skips the write.
// Clear wait, reset and unused kinds go straight to the done state.
// Tick and dequeue: read, tag and update states per queued entry visited, set by the queue and wait RAM reads.
// One item at a time; the result is registered out of the done state and may wait for out_ready.
// The next item can be taken in the same cycle as the result is shown.
// rst_n clears the queue, the per-tag valid bits and loads the register defaults; the reset
// kind clears the same state and keeps the registers.
module backoff_retry_request_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  brq_pkg::req_t                       req,
    output logic                                out_valid,
    input  logic                                out_ready,
    output brq_pkg::rsp_t                       rsp,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [brq_pkg::INTERVAL_W-1:0]      cfg_data
);

    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = brq_pkg::TAG_W;
    localparam int WW    = brq_pkg::WAIT_W;
    localparam int NT    = brq_pkg::TAG_COUNT;

    brq_pkg::state_t state_reg, state_next;

    logic [brq_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [TW-1:0]                  tag_reg, tag_next;
    logic [brq_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [TW-1:0]                  cur_reg, cur_next;
    logic [QA_W-1:0]                head_reg, head_next;
    logic [QA_W-1:0]                tail_reg, tail_next;
    logic [QA_W-1:0]                scan_reg, scan_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [NT-1:0]                  queued_reg, queued_next;
    logic [NT-1:0]                  wpres_reg, wpres_next;
    logic [NT-1:0]                  hpres_reg, hpres_next;
    brq_pkg::rsp_t                  res_reg, res_next;
    brq_pkg::rsp_t                  out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    logic [brq_pkg::INTERVAL_W-1:0] interval_reg;
    logic [WW-1:0]                  cap_reg;

    logic                           accept;
    logic [QA_W-1:0]                scan_inc, tail_inc;
    logic                           last_entry;

    logic                           q_we;
    logic [TW-1:0]                  q_rd;
    logic                           w_we;
    logic [TW-1:0]                  w_addr;
    logic [2*WW-1:0]                w_wdata, w_rd;
    logic                           h_we;
    logic [brq_pkg::TIME_W-1:0]     h_rd;

    brq_pkg::unit_op_t              u_op;
    logic [brq_pkg::TIME_W-1:0]     u_a, u_b, u_y;
    logic                           u_flag;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == brq_pkg::S_IDLE);
    assign out_valid  = out_valid_reg;
    assign rsp        = out_reg;
    assign scan_inc   = (scan_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : scan_reg + 1'b1;
    assign tail_inc   = (tail_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign last_entry = ((idx_reg + 1'b1) == count_reg);
    // wait RAM follows the scanned tag while walking the queue
    assign w_addr     = (state_reg == brq_pkg::S_TK_TAG || state_reg == brq_pkg::S_DQ_TAG)
                        ? q_rd : tag_reg;

    brq_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (tail_reg),
        .wr_data ((state_reg == brq_pkg::S_ENQ_WR) ? tag_reg : cur_reg),
        .rd_addr (scan_reg),
        .rd_data (q_rd)
    );

    // upper half last wait, lower half remaining wait
    brq_ram #(.WIDTH(2 * WW), .DEPTH(NT)) u_wait (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr ((state_reg == brq_pkg::S_TK_UPD) ? cur_reg : tag_reg),
        .wr_data (w_wdata),
        .rd_addr (w_addr),
        .rd_data (w_rd)
    );

    brq_ram #(.WIDTH(brq_pkg::TIME_W), .DEPTH(NT)) u_holdoff (
        .clk     (clk),
        .wr_en   (h_we),
        .wr_addr (tag_reg),
        .wr_data (u_y),
        .rd_addr (tag_reg),
        .rd_data (h_rd)
    );

    brq_unit u_unit (
        .op   (u_op),
        .a    (u_a),
        .b    (u_b),
        .y    (u_y),
        .flag (u_flag)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        brq_pkg::KIND_ENQ,
                        brq_pkg::KIND_BACKOFF: state_next = brq_pkg::S_LOOK;
                        brq_pkg::KIND_TICK:
                            state_next = (count_reg == '0) ? brq_pkg::S_DONE : brq_pkg::S_TK_RD;
                        brq_pkg::KIND_DEQ:
                            state_next = (count_reg == '0) ? brq_pkg::S_DONE : brq_pkg::S_DQ_RD;
                        default: state_next = brq_pkg::S_DONE;
                    endcase
                end
            end
            brq_pkg::S_LOOK:
                state_next = (kind_reg == brq_pkg::KIND_BACKOFF) ? brq_pkg::S_BACKOFF
                                                                 : brq_pkg::S_ENQ_CHK;
            brq_pkg::S_BACKOFF: state_next = brq_pkg::S_ENQ_CHK;
            brq_pkg::S_ENQ_CHK:
            begin
                if (queued_reg[tag_reg] || (hpres_reg[tag_reg] && u_flag)
                    || count_reg >= CNT_W'(QUEUE_DEPTH))
                begin
                    state_next = brq_pkg::S_DONE;
                end
                else
                begin
                    state_next = brq_pkg::S_ENQ_WR;
                end
            end
            brq_pkg::S_ENQ_WR: state_next = brq_pkg::S_DONE;
            brq_pkg::S_TK_RD:  state_next = brq_pkg::S_TK_TAG;
            brq_pkg::S_TK_TAG: state_next = brq_pkg::S_TK_UPD;
            brq_pkg::S_TK_UPD: state_next = last_entry ? brq_pkg::S_DONE : brq_pkg::S_TK_RD;
            brq_pkg::S_DQ_RD:  state_next = brq_pkg::S_DQ_TAG;
            brq_pkg::S_DQ_TAG: state_next = brq_pkg::S_DQ_DEC;
            brq_pkg::S_DQ_DEC:
            begin
                if (!wpres_reg[cur_reg] || !u_flag || last_entry)
                begin
                    state_next = brq_pkg::S_DONE;
                end
                else
                begin
                    state_next = brq_pkg::S_DQ_RD;
                end
            end
            brq_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = brq_pkg::S_IDLE;
                end
            end
            default: state_next = brq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        kind_next      = kind_reg;
        tag_next       = tag_reg;
        now_next       = now_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        queued_next    = queued_reg;
        wpres_next     = wpres_reg;
        hpres_next     = hpres_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_we           = 1'b0;
        w_we           = 1'b0;
        w_wdata        = w_rd;
        h_we           = 1'b0;
        u_op           = brq_pkg::UOP_LE;
        u_a            = now_reg;
        u_b            = h_rd;
        case (state_reg)
            brq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req.kind;
                    tag_next  = req.request_tag;
                    now_next  = req.now_time;
                    res_next  = '0;
                    idx_next  = '0;
                    scan_next = head_reg;
                    if (req.kind == brq_pkg::KIND_CLEAR)
                    begin
                        wpres_next[req.request_tag] = 1'b0;
                    end
                    else if (req.kind == brq_pkg::KIND_RESET)
                    begin
                        queued_next = '0;
                        wpres_next  = '0;
                        hpres_next  = '0;
                        count_next  = '0;
                        head_next   = '0;
                        tail_next   = '0;
                    end
                end
            end
            brq_pkg::S_BACKOFF:
            begin
                // an absent wait is taken as zero; the unit doubles a zero wait as one
                u_op    = brq_pkg::UOP_DBL;
                u_a     = brq_pkg::TIME_W'(wpres_reg[tag_reg] ? w_rd[2*WW-1:WW] : '0);
                u_b     = brq_pkg::TIME_W'(cap_reg);
                w_we    = 1'b1;
                w_wdata = {u_y[WW-1:0], u_y[WW-1:0]};
                wpres_next[tag_reg] = 1'b1;
            end
            brq_pkg::S_ENQ_CHK:
            begin
                u_op = brq_pkg::UOP_LE;
                if (queued_reg[tag_reg])
                begin
                    res_next.status = brq_pkg::ST_QUEUED;
                end
                else if (hpres_reg[tag_reg] && u_flag)
                begin
                    res_next.status = brq_pkg::ST_HELD;
                end
                else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                begin
                    res_next.status = brq_pkg::ST_FULL;
                end
            end
            brq_pkg::S_ENQ_WR:
            begin
                u_op       = brq_pkg::UOP_ADD;
                u_b        = brq_pkg::TIME_W'(interval_reg);
                h_we       = 1'b1;
                q_we       = 1'b1;
                tail_next  = tail_inc;
                count_next = count_reg + 1'b1;
                queued_next[tag_reg] = 1'b1;
                hpres_next[tag_reg]  = 1'b1;
            end
            brq_pkg::S_TK_TAG,
            brq_pkg::S_DQ_TAG:
            begin
                cur_next = q_rd;
            end
            brq_pkg::S_TK_UPD:
            begin
                u_op      = brq_pkg::UOP_DEC;
                u_a       = brq_pkg::TIME_W'(w_rd[WW-1:0]);
                w_we      = wpres_reg[cur_reg] && u_flag;
                w_wdata   = {w_rd[2*WW-1:WW], u_y[WW-1:0]};
                scan_next = scan_inc;
                idx_next  = idx_reg + 1'b1;
            end
            brq_pkg::S_DQ_DEC:
            begin
                u_op      = brq_pkg::UOP_DEC;
                u_a       = brq_pkg::TIME_W'(w_rd[WW-1:0]);
                scan_next = scan_inc;
                head_next = scan_inc;
                if (!wpres_reg[cur_reg] || !u_flag)
                begin
                    count_next           = count_reg - 1'b1;
                    queued_next[cur_reg] = 1'b0;
                    res_next.granted     = 1'b1;
                    res_next.granted_tag = cur_reg;
                end
                else
                begin
                    // passed-over item goes to the back; a full lap restores the order
                    q_we      = 1'b1;
                    tail_next = tail_inc;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            brq_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                u_op = brq_pkg::UOP_LE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brq_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            queued_reg    <= '0;
            wpres_reg     <= '0;
            hpres_reg     <= '0;
            out_valid_reg <= 1'b0;
            interval_reg  <= brq_pkg::HOLDOFF_RESET;
            cap_reg       <= brq_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            queued_reg    <= queued_next;
            wpres_reg     <= wpres_next;
            hpres_reg     <= hpres_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == brq_pkg::CFG_HOLDOFF_INTERVAL)
            begin
                interval_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == brq_pkg::CFG_BACKOFF_CAP)
            begin
                cap_reg <= cfg_data[WW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        tag_reg  <= tag_next;
        now_reg  <= now_next;
        cur_reg  <= cur_next;
        scan_reg <= scan_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

[src/brq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/brq_unit.sv]
// Shared arithmetic unit: time add, time compare, capped doubling, saturating decrement.
// Depends on brq_pkg.
module brq_unit (
    input  brq_pkg::unit_op_t                op,
    input  logic [brq_pkg::TIME_W-1:0]       a,
    input  logic [brq_pkg::TIME_W-1:0]       b,
    output logic [brq_pkg::TIME_W-1:0]       y,
    output logic                             flag
);

    logic [brq_pkg::WAIT_W-1:0] base;
    logic [brq_pkg::WAIT_W-1:0] capx;
    logic [brq_pkg::WAIT_W:0]   dbl;

    always_comb
    begin
        base = (a[brq_pkg::WAIT_W-1:0] == '0) ? brq_pkg::WAIT_W'(1) : a[brq_pkg::WAIT_W-1:0];
        dbl  = {base, 1'b0};
        capx = (b[brq_pkg::WAIT_W-1:0] < brq_pkg::WAIT_W'(2)) ? brq_pkg::WAIT_W'(2)
                                                             : b[brq_pkg::WAIT_W-1:0];
        y    = '0;
        flag = 1'b0;
        case (op)
            brq_pkg::UOP_ADD:
            begin
                y = a + b;
            end
            brq_pkg::UOP_LE:
            begin
                flag = (a <= b);
            end
            brq_pkg::UOP_DBL:
            begin
                y = brq_pkg::TIME_W'((dbl > {1'b0, capx}) ? capx : dbl[brq_pkg::WAIT_W-1:0]);
            end
            brq_pkg::UOP_DEC:
            begin
                flag = (a[brq_pkg::WAIT_W-1:0] != '0);
                y    = flag ? brq_pkg::TIME_W'(a[brq_pkg::WAIT_W-1:0] - 1'b1) : '0;
            end
            default:
            begin
                y = '0;
            end
        endcase
    end

endmodule
